@@ rtl/core/gsa_pkg.sv @@
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared widths, op codes, state encoding and saturation helpers for the
// mixture statistics accumulator.
// ----------------------------------------------------------------------------
package gsa_pkg;

  localparam int OP_W      = 3;
  localparam int GAUSS_W   = 8;
  localparam int DIM_IDX_W = 6;
  localparam int SAMPLE_W  = 16;
  localparam int WEIGHT_W  = 16;
  localparam int COUNT_W   = 32;
  localparam int STAT_W    = 48;
  localparam int MAX_ROWS  = 1 << GAUSS_W;

  typedef logic        [OP_W-1:0]     op_t;
  typedef logic        [GAUSS_W-1:0]  gauss_t;
  typedef logic        [DIM_IDX_W-1:0] dim_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [WEIGHT_W-1:0] weight_t;
  typedef logic        [COUNT_W-1:0]  count_t;
  typedef logic signed [STAT_W-1:0]   stat_t;

  localparam op_t OP_CLEAR      = 3'd0;
  localparam op_t OP_LOAD_MEAN  = 3'd1;
  localparam op_t OP_LOAD_FRAME = 3'd2;
  localparam op_t OP_POSTERIOR  = 3'd3;
  localparam op_t OP_READ       = 3'd4;

  localparam count_t COUNT_MAX = '1;
  localparam stat_t  STAT_MAX  = {1'b0, {(STAT_W-1){1'b1}}};
  localparam stat_t  STAT_MIN  = {1'b1, {(STAT_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POST,
    ST_RD_MUL,
    ST_RD_OUT
  } state_t;

  // clamp a two-bit-wider signed value to the stat range
  function automatic stat_t sat_stat(input logic signed [STAT_W+1:0] v);
    stat_t res;
    if ((v[STAT_W+1] == v[STAT_W]) && (v[STAT_W] == v[STAT_W-1])) begin
      res = v[STAT_W-1:0];
    end else if (v[STAT_W+1]) begin
      res = STAT_MIN;
    end else begin
      res = STAT_MAX;
    end
    return res;
  endfunction

  function automatic count_t sat_count(input logic [COUNT_W:0] v);
    count_t res;
    res = v[COUNT_W] ? COUNT_MAX : v[COUNT_W-1:0];
    return res;
  endfunction

endpackage

@@ rtl/core/gsa_in_if.sv @@
// ----------------------------------------------------------------------------
// gsa_in_if
// Input item channel: valid/ready handshake with the op and its operands.
// ----------------------------------------------------------------------------
interface gsa_in_if;
  import gsa_pkg::*;

  logic    valid;
  logic    ready;
  op_t     op;
  gauss_t  gauss_index;
  dim_t    dim_index;
  sample_t sample_value;
  weight_t post_weight;

  modport source (
    output valid, op, gauss_index, dim_index, sample_value, post_weight,
    input  ready
  );

  modport sink (
    input  valid, op, gauss_index, dim_index, sample_value, post_weight,
    output ready
  );
endinterface

@@ rtl/core/gsa_out_if.sv @@
// ----------------------------------------------------------------------------
// gsa_out_if
// Result item channel: valid/ready handshake with count and centered stat.
// ----------------------------------------------------------------------------
interface gsa_out_if;
  import gsa_pkg::*;

  logic   valid;
  logic   ready;
  count_t count_out;
  stat_t  centered_stat;

  modport source (
    output valid, count_out, centered_stat,
    input  ready
  );

  modport sink (
    input  valid, count_out, centered_stat,
    output ready
  );
endinterface

@@ rtl/core/gmm_stats_accumulator.sv @@
// ----------------------------------------------------------------------------
// gmm_stats_accumulator
// Zeroth- and first-order statistics per mixture component, centered on read.
//
// Load mean, load frame element and clear never hold the input; clear drops a
// per-component valid bit, so no sweep of the memories is needed after reset
// or clear. While a posterior item is in flight the input stays closed: the
// component row is walked one element per cycle through a read, a registered
// multiply and a saturating write back on the single read port of the
// first-order memory, and the walk drains before the input opens again.
// A read item goes through a memory read and a registered multiply to its
// result register, held back while the previous result waits to be taken.
// The next item is accepted while a result waits on the output.
// ----------------------------------------------------------------------------
module gmm_stats_accumulator #(
  parameter int NUM_COMPONENTS = 256,
  parameter int NUM_DIMS       = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  gsa_in_if.sink   in_ch,
  gsa_out_if.source out_ch
);
  import gsa_pkg::*;

  localparam int NUM_ROWS = (NUM_COMPONENTS < MAX_ROWS) ? NUM_COMPONENTS : MAX_ROWS;
  localparam int ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int DIM_W    = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
  localparam int DEPTH    = NUM_ROWS * NUM_DIMS;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [DIM_W-1:0] LAST_DIM = DIM_W'(NUM_DIMS - 1);
  localparam int PROD_W   = SAMPLE_W + WEIGHT_W + 1;
  localparam int CM_W     = SAMPLE_W + COUNT_W + 1;

  // control
  state_t state_r, state_nxt;
  logic   in_ready;
  logic   accept;
  logic   issue;
  logic   row_set;
  logic   out_load;
  logic   first_r;
  logic   issue_done_r;
  logic   p1_vld_r, p2_vld_r;
  logic   [DIM_W-1:0] k_r;
  logic   [NUM_ROWS-1:0] row_valid_r;
  logic   out_valid_r;

  // decoded input
  logic [ROW_W-1:0]  in_row;
  logic [DIM_W-1:0]  in_dim;
  logic [ADDR_W-1:0] in_addr;
  logic              g_ok, d_ok;

  // item registers
  logic [ROW_W-1:0]  row_r;
  logic [ADDR_W-1:0] base_r;
  weight_t           w_r;
  logic              row_live_r;
  logic              g_ok_r, d_ok_r;

  // posterior pipeline
  logic [ADDR_W-1:0]        issue_addr;
  logic [ADDR_W-1:0]        p1_addr_r, p2_addr_r;
  logic signed [PROD_W-1:0] prod_r;
  stat_t                    old_r;
  stat_t                    fo_wdata;
  count_t                   cnt_old;
  count_t                   cnt_wdata;

  // read path
  count_t                 cnt_eff;
  logic signed [CM_W-1:0] cm_r;
  stat_t                  fo_hold_r;
  count_t                 cnt_hold_r;
  logic signed [STAT_W+1:0] diff;

  // output registers
  count_t out_count_r;
  stat_t  out_stat_r;

  // memories
  count_t  cnt_mem   [NUM_ROWS];
  stat_t   fo_mem    [DEPTH];
  sample_t mean_mem  [DEPTH];
  sample_t frame_mem [NUM_DIMS];
  count_t  cnt_rdata_r;
  stat_t   fo_rdata_r;
  sample_t mean_rdata_r;
  sample_t frame_rdata_r;
  logic [ADDR_W-1:0] fo_raddr;
  logic    mean_we, frame_we;

  assign in_row  = ROW_W'(in_ch.gauss_index);
  assign in_dim  = DIM_W'(in_ch.dim_index);
  assign in_addr = ADDR_W'(in_row) * ADDR_W'(NUM_DIMS) + ADDR_W'(in_dim);
  assign g_ok    = 32'(in_ch.gauss_index) < NUM_COMPONENTS;
  assign d_ok    = 32'(in_ch.dim_index) < NUM_DIMS;

  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    issue     = 1'b0;
    row_set   = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.op == OP_POSTERIOR && g_ok) begin
            state_nxt = ST_POST;
          end else if (in_ch.op == OP_READ) begin
            state_nxt = ST_RD_MUL;
          end
        end
      end
      ST_POST: begin
        issue = !issue_done_r;
        if (issue_done_r && !p1_vld_r && !p2_vld_r) begin
          row_set   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_RD_MUL: begin
        state_nxt = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      first_r      <= 1'b0;
      issue_done_r <= 1'b1;
      p1_vld_r     <= 1'b0;
      p2_vld_r     <= 1'b0;
      k_r          <= '0;
      row_valid_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      first_r  <= accept && in_ch.op == OP_POSTERIOR && g_ok;
      p1_vld_r <= issue;
      p2_vld_r <= p1_vld_r;
      if (accept) begin
        k_r          <= '0;
        issue_done_r <= 1'b0;
      end else if (issue) begin
        k_r <= k_r + DIM_W'(1);
        if (k_r == LAST_DIM) begin
          issue_done_r <= 1'b1;
        end
      end
      if (accept && in_ch.op == OP_CLEAR) begin
        row_valid_r <= '0;
      end else if (row_set) begin
        row_valid_r[row_r] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item capture and posterior datapath
  assign issue_addr = base_r + ADDR_W'(k_r);
  assign cnt_old    = row_live_r ? cnt_rdata_r : '0;
  assign cnt_wdata  = sat_count({1'b0, cnt_old} + (COUNT_W+1)'(w_r));
  assign fo_wdata   = sat_stat($signed({{2{old_r[STAT_W-1]}}, old_r})
                             + $signed({{(STAT_W+2-PROD_W){prod_r[PROD_W-1]}}, prod_r}));

  always_ff @(posedge clk) begin
    if (accept) begin
      row_r      <= in_row;
      base_r     <= ADDR_W'(in_row) * ADDR_W'(NUM_DIMS);
      w_r        <= in_ch.post_weight;
      row_live_r <= g_ok && row_valid_r[in_row];
      g_ok_r     <= g_ok;
      d_ok_r     <= d_ok;
    end
    p1_addr_r <= issue_addr;
    p2_addr_r <= p1_addr_r;
    prod_r    <= $signed({{(PROD_W-WEIGHT_W){1'b0}}, w_r}) * PROD_W'(frame_rdata_r);
    old_r     <= row_live_r ? fo_rdata_r : '0;
  end

  // read datapath
  assign cnt_eff = row_live_r ? cnt_rdata_r : '0;
  assign diff    = $signed({{2{fo_hold_r[STAT_W-1]}}, fo_hold_r})
                 - $signed({{(STAT_W+2-CM_W){cm_r[CM_W-1]}}, cm_r});

  always_ff @(posedge clk) begin
    if (state_r == ST_RD_MUL) begin
      cm_r       <= $signed({{(CM_W-COUNT_W){1'b0}}, cnt_eff}) * CM_W'(mean_rdata_r);
      fo_hold_r  <= row_live_r ? fo_rdata_r : '0;
      cnt_hold_r <= cnt_eff;
    end
    if (out_load) begin
      out_count_r <= cnt_hold_r;
      out_stat_r  <= (g_ok_r && d_ok_r) ? sat_stat(diff) : '0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.count_out     = out_count_r;
  assign out_ch.centered_stat = out_stat_r;

  // storage
  assign fo_raddr = (state_r == ST_POST) ? issue_addr : in_addr;
  assign mean_we  = accept && in_ch.op == OP_LOAD_MEAN && g_ok && d_ok;
  assign frame_we = accept && in_ch.op == OP_LOAD_FRAME && d_ok;

  always_ff @(posedge clk) begin
    if (first_r) begin
      cnt_mem[row_r] <= cnt_wdata;
    end
    cnt_rdata_r <= cnt_mem[in_row];
  end

  always_ff @(posedge clk) begin
    if (p2_vld_r) begin
      fo_mem[p2_addr_r] <= fo_wdata;
    end
    fo_rdata_r <= fo_mem[fo_raddr];
  end

  always_ff @(posedge clk) begin
    if (mean_we) begin
      mean_mem[in_addr] <= in_ch.sample_value;
    end
    mean_rdata_r <= mean_mem[in_addr];
  end

  always_ff @(posedge clk) begin
    if (frame_we) begin
      frame_mem[in_dim] <= in_ch.sample_value;
    end
    frame_rdata_r <= frame_mem[k_r];
  end

`ifndef ASSERT_OFF
  // a new item never lands on a row update still in flight
  a_drained_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !p1_vld_r && !p2_vld_r)
    else $error("item accepted with row update in flight");

  a_row_write_in_post: assert property (@(posedge clk) disable iff (!rst_n)
    p2_vld_r |-> state_r == ST_POST)
    else $error("first-order write outside posterior");

  a_count_write_first: assert property (@(posedge clk) disable iff (!rst_n)
    first_r |-> state_r == ST_POST && k_r == '0 && !issue_done_r)
    else $error("count write out of step with row walk");

  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_RD_OUT)
    else $error("result raised without a read item");
`endif

endmodule

@@ test/tb_gmm_stats_accumulator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gmm_stats_accumulator
// Self-checking bench for the mixture statistics accumulator. Items go in
// through the input channel with random gaps. Each accepted item also updates
// a fixed-point copy of the occupancy counts, first-order rows, means and
// frame. Every read item queues the count and centered value it must return,
// and each result taken from the output channel is compared field by field.
// Covers corner values, unused op codes, clear, output backpressure, long
// accumulation into one component and random component sequences.
// ----------------------------------------------------------------------------
module tb_gmm_stats_accumulator;
  import gsa_pkg::*;

  localparam int NUM_COMP      = 256;
  localparam int NUM_DIMS      = 64;
  localparam int ROW_WORDS     = NUM_COMP * NUM_DIMS;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 100;
  localparam int HEAVY_POSTS   = 40;

  localparam longint ROW_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ROW_LO = -ROW_HI - 1;

  localparam op_t OP_RSVD5 = 3'd5;
  localparam op_t OP_RSVD6 = 3'd6;
  localparam op_t OP_RSVD7 = 3'd7;

  localparam sample_t Q88_MIN = 16'sh8000;
  localparam sample_t Q88_MAX = 16'sh7FFF;

  typedef struct {
    op_t     op;
    gauss_t  gauss;
    dim_t    dim;
    sample_t sample;
    weight_t weight;
  } stats_req_t;

  typedef struct {
    count_t count;
    stat_t  stat;
  } read_result_t;

  logic clk;
  logic rst_n;

  gsa_in_if  in_ch ();
  gsa_out_if out_ch ();

  gmm_stats_accumulator #(
    .NUM_COMPONENTS(NUM_COMP),
    .NUM_DIMS      (NUM_DIMS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  count_t  occ_count   [NUM_COMP];
  stat_t   first_order [ROW_WORDS];
  sample_t comp_mean   [ROW_WORDS];
  bit      mean_loaded [ROW_WORDS];
  sample_t frame_elem  [NUM_DIMS];

  int           loaded_means  [$];
  read_result_t pending_reads [$];

  bit idle_on;
  int out_hold_cycles;
  int fail_count;
  int cycle_count;
  int sent_items;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic stat_t clamp_row(input longint v);
    if (v > ROW_HI) return STAT_MAX;
    if (v < ROW_LO) return STAT_MIN;
    return stat_t'(v);
  endfunction

  function automatic void zero_stats();
    foreach (occ_count[i]) occ_count[i] = '0;
    foreach (first_order[i]) first_order[i] = '0;
  endfunction

  function automatic void predict_stats(input stats_req_t r);
    int               base;
    int               at;
    logic [COUNT_W:0] csum;
    longint           acc;
    read_result_t     res;
    base = int'(r.gauss) * NUM_DIMS;
    at   = base + int'(r.dim);
    case (r.op)
      OP_CLEAR: begin
        zero_stats();
      end
      OP_LOAD_MEAN: begin
        comp_mean[at] = r.sample;
        if (!mean_loaded[at]) begin
          mean_loaded[at] = 1'b1;
          loaded_means = {loaded_means, at};
        end
      end
      OP_LOAD_FRAME: begin
        frame_elem[r.dim] = r.sample;
      end
      OP_POSTERIOR: begin
        csum = {1'b0, occ_count[r.gauss]} + r.weight;
        occ_count[r.gauss] = csum[COUNT_W] ? '1 : csum[COUNT_W-1:0];
        for (int k = 0; k < NUM_DIMS; k++) begin
          acc = longint'(first_order[base+k]) +
                longint'(r.weight) * longint'(frame_elem[k]);
          first_order[base+k] = clamp_row(acc);
        end
      end
      OP_READ: begin
        acc = longint'(first_order[at]) -
              longint'(occ_count[r.gauss]) * longint'(comp_mean[at]);
        res.count = occ_count[r.gauss];
        res.stat  = clamp_row(acc);
        pending_reads = {pending_reads, res};
      end
      default: ;
    endcase
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return Q88_MIN;
      1:       return Q88_MAX;
      2:       return '0;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic weight_t rand_weight();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return weight_t'($urandom);
    endcase
  endfunction

  task automatic send_req(input op_t op, input gauss_t g, input dim_t d,
                          input sample_t s, input weight_t w);
    stats_req_t req;
    req.op     = op;
    req.gauss  = g;
    req.dim    = d;
    req.sample = s;
    req.weight = w;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.gauss_index  <= g;
    in_ch.dim_index    <= d;
    in_ch.sample_value <= s;
    in_ch.post_weight  <= w;
    do @(posedge clk); while (!in_ch.ready);
    predict_stats(req);
    if (op <= OP_READ) sent_items++;
  endtask

  // only entries whose mean was loaded are ever read
  task automatic read_loaded_mean();
    int at;
    at = loaded_means[$urandom_range(0, loaded_means.size() - 1)];
    send_req(OP_READ, gauss_t'(at / NUM_DIMS), dim_t'(at % NUM_DIMS),
             rand_sample(), rand_weight());
  endtask

  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_reads.size() != 0);
  endtask

  task automatic test_frame_setup();
    sample_t s;
    for (int k = 0; k < NUM_DIMS; k++) begin
      case (k)
        0:       s = Q88_MIN;
        1:       s = '0;
        2:       s = '1;
        3:       s = 16'sd1;
        63:      s = Q88_MAX;
        default: s = sample_t'($urandom);
      endcase
      send_req(OP_LOAD_FRAME, gauss_t'($urandom), dim_t'(k), s, rand_weight());
    end
  endtask

  task automatic test_extremes();
    send_req(OP_LOAD_MEAN, 8'd255, 6'd63, Q88_MAX, '0);
    send_req(OP_LOAD_MEAN, 8'd255, 6'd0, Q88_MIN, '1);
    send_req(OP_LOAD_MEAN, 8'd0, 6'd0, '0, '0);
    send_req(OP_LOAD_MEAN, 8'd0, 6'd63, '1, '1);
    send_req(OP_POSTERIOR, 8'd255, 6'd63, Q88_MAX, '1);
    send_req(OP_POSTERIOR, 8'd255, 6'd0, Q88_MIN, '1);
    send_req(OP_POSTERIOR, 8'd0, 6'd0, '0, '0);
    send_req(OP_POSTERIOR, 8'd0, 6'd63, '1, 16'd1);
    send_req(OP_READ, 8'd255, 6'd63, '0, '0);
    send_req(OP_READ, 8'd255, 6'd0, '1, '1);
    send_req(OP_READ, 8'd0, 6'd0, Q88_MIN, '0);
    send_req(OP_READ, 8'd0, 6'd63, Q88_MAX, '1);
    send_req(OP_LOAD_MEAN, 8'd255, 6'd63, Q88_MIN, '0);
    send_req(OP_READ, 8'd255, 6'd63, '0, '0);
  endtask

  task automatic test_unused_ops();
    for (int i = int'(OP_RSVD5); i <= int'(OP_RSVD7); i++) begin
      send_req(op_t'(i), gauss_t'($urandom), dim_t'($urandom),
               rand_sample(), rand_weight());
      read_loaded_mean();
    end
  endtask

  task automatic test_clear();
    send_req(OP_LOAD_MEAN, 8'd7, 6'd5, rand_sample(), '0);
    send_req(OP_POSTERIOR, 8'd7, '0, '0, rand_weight());
    send_req(OP_READ, 8'd7, 6'd5, '0, '0);
    send_req(OP_CLEAR, gauss_t'($urandom), dim_t'($urandom), rand_sample(), rand_weight());
    send_req(OP_READ, 8'd7, 6'd5, '0, '0);
    send_req(OP_READ, 8'd255, 6'd63, '0, '0);
    send_req(OP_POSTERIOR, 8'd7, '0, '0, '1);
    send_req(OP_CLEAR, '0, '0, '0, '0);
    send_req(OP_CLEAR, '1, '1, '1, '1);
    send_req(OP_READ, 8'd7, 6'd5, '0, '0);
  endtask

  // receiver holds off while reads keep coming, then the sender waits it out
  task automatic test_output_backpressure();
    out_hold_cycles = 400;
    for (int i = 0; i < 8; i++) begin
      if (i == 3)
        send_req(OP_POSTERIOR, gauss_t'($urandom), '0, '0, rand_weight());
      read_loaded_mean();
    end
    pause_until_drained();
  endtask

  // long run of heavy posteriors into one component, opposite-sign mean
  task automatic test_heavy_accumulation();
    gauss_t g;
    g = gauss_t'($urandom);
    for (int k = 0; k < NUM_DIMS; k++) begin
      send_req(OP_LOAD_FRAME, g, dim_t'(k), k[0] ? Q88_MIN : Q88_MAX, rand_weight());
      send_req(OP_LOAD_MEAN, g, dim_t'(k), k[0] ? Q88_MAX : Q88_MIN, rand_weight());
    end
    for (int n = 0; n < HEAVY_POSTS; n++) begin
      send_req(OP_POSTERIOR, g, dim_t'($urandom), rand_sample(),
               weight_t'($urandom_range(60000, 65535)));
      if (n % 20 == 19)
        send_req(OP_READ, g, dim_t'($urandom), rand_sample(), rand_weight());
    end
    for (int k = 0; k < NUM_DIMS; k++)
      send_req(OP_READ, g, dim_t'(k), rand_sample(), rand_weight());
  endtask

  task automatic test_random_traffic(input int n_items);
    int     stop_at;
    int     n_dims;
    gauss_t g;
    dim_t   dims [4];
    stop_at = sent_items + n_items;
    while (sent_items < stop_at) begin
      if ($urandom_range(0, 9) < 7) begin
        // means for one component, maybe a frame tweak, posteriors, reads back
        g = gauss_t'($urandom);
        n_dims = $urandom_range(1, 4);
        for (int i = 0; i < n_dims; i++) begin
          dims[i] = dim_t'($urandom);
          send_req(OP_LOAD_MEAN, g, dims[i], rand_sample(), rand_weight());
        end
        if ($urandom_range(0, 2) == 0)
          send_req(OP_LOAD_FRAME, gauss_t'($urandom), dim_t'($urandom),
                   rand_sample(), rand_weight());
        repeat ($urandom_range(1, 3))
          send_req(OP_POSTERIOR, g, dim_t'($urandom), rand_sample(), rand_weight());
        repeat ($urandom_range(1, 3))
          send_req(OP_READ, g, dims[$urandom_range(0, n_dims - 1)],
                   rand_sample(), rand_weight());
      end else begin
        case ($urandom_range(0, 19))
          0: send_req(OP_CLEAR, gauss_t'($urandom), dim_t'($urandom),
                      rand_sample(), rand_weight());
          1, 2, 3, 4: send_req(OP_LOAD_MEAN, gauss_t'($urandom), dim_t'($urandom),
                               rand_sample(), rand_weight());
          5, 6, 7: send_req(OP_LOAD_FRAME, gauss_t'($urandom), dim_t'($urandom),
                            rand_sample(), rand_weight());
          8, 9, 10, 11: send_req(OP_POSTERIOR, gauss_t'($urandom), dim_t'($urandom),
                                 rand_sample(), rand_weight());
          12, 13, 14, 15, 16, 17: read_loaded_mean();
          default: send_req(op_t'($urandom_range(int'(OP_RSVD5), int'(OP_RSVD7))),
                            gauss_t'($urandom), dim_t'($urandom),
                            rand_sample(), rand_weight());
        endcase
      end
    end
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    test_random_traffic(40);
  endtask

  // result receiver
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_hold_cycles > 0) begin
        out_hold_cycles--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    read_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_reads.size() == 0) begin
        $error("unexpected result item: count_out %0d centered_stat %0d",
               out_ch.count_out, out_ch.centered_stat);
        fail_count++;
      end else begin
        want = pending_reads.pop_front();
        if (out_ch.count_out !== want.count) begin
          $error("count_out mismatch: expected %0d, actual %0d",
                 want.count, out_ch.count_out);
          fail_count++;
        end
        if (out_ch.centered_stat !== want.stat) begin
          $error("centered_stat mismatch: expected %0d, actual %0d",
                 want.stat, out_ch.centered_stat);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** gmm_stats_accumulator: FAILED **");
      $finish;
    end
  end

  initial begin
    idle_on = 1'b1;
    zero_stats();
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.op           <= OP_CLEAR;
    in_ch.gauss_index  <= '0;
    in_ch.dim_index    <= '0;
    in_ch.sample_value <= '0;
    in_ch.post_weight  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_frame_setup();
    test_extremes();
    test_unused_ops();
    test_clear();
    test_output_backpressure();
    test_heavy_accumulation();
    test_random_traffic(70);
    test_steady_stream();

    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** gmm_stats_accumulator: PASSED **");
    end else begin
      $display("** gmm_stats_accumulator: FAILED **");
    end
    $finish;
  end

endmodule
